### rtl/grid_neighbor_expander_core_assert.svh
// Assertion macros for the grid neighbor expander checker.
// Include with the bare file name; no other dependencies.
`ifndef GRID_NEIGHBOR_EXPANDER_CORE_ASSERT_SVH
`define GRID_NEIGHBOR_EXPANDER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define GNE_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define GNE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gne_pkg.sv
// Shared types, constants and the microcode table of the grid neighbor expander.
// No dependencies; imported by every module of the block but gne_ram.
package gne_pkg;

    localparam int IDX_W       = 12;
    localparam int MAP_DEPTH   = 1 << IDX_W;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int DEG_W       = 4;
    localparam int NUM_DIRS    = 8;
    localparam int DIR_W       = 3;
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    // Signed width for cell index plus neighbor offset.
    localparam int SA_W        = IDX_W + 2;

    localparam int DIV_STEPS = IDX_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 2);

    typedef logic [DIR_W-1:0]  dir_t;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_EVAL = step_t'(DIV_STEPS);
    localparam step_t STEP_EMIT = step_t'(DIV_STEPS + 1);

    localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = CFG_W'(64);
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = CFG_W'(64);
    localparam logic [DEG_W-1:0] DEG_MAX         = DEG_W'(NUM_DIRS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_WIDTH  = 3'd0,
        REG_GRID_HEIGHT = 3'd1,
        REG_DIAG_EN     = 3'd2,
        REG_CUT_EN      = 3'd3,
        REG_SQZ_EN      = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    typedef struct packed {
        logic  div_en;
        logic  rd_en;
        dir_t  rd_dir;
        logic  cap_en;
        dir_t  cap_dir;
        logic  eval_en;
        logic  emit_en;
        logic  jmp_more;
        step_t target;
        logic  fin;
    } ucode_t;

    // Direction codes: dx outer from -1 to 1, dy inner, center skipped.
    function automatic logic signed [1:0] dir_dx(input dir_t d);
        logic signed [1:0] v;
        case (d)
            3'd0, 3'd1, 3'd2: v = -2'sd1;
            3'd3, 3'd4:       v = 2'sd0;
            default:          v = 2'sd1;
        endcase
        return v;
    endfunction

    function automatic logic signed [1:0] dir_dy(input dir_t d);
        logic signed [1:0] v;
        case (d)
            3'd0, 3'd3, 3'd5: v = -2'sd1;
            3'd1, 3'd6:       v = 2'sd0;
            default:          v = 2'sd1;
        endcase
        return v;
    endfunction

    // Direction of the side cell (dx, 0).
    function automatic dir_t dir_side_x(input dir_t d);
        dir_t v;
        case (d)
            3'd0, 3'd2: v = 3'd1;
            3'd5, 3'd7: v = 3'd6;
            default:    v = d;
        endcase
        return v;
    endfunction

    // Direction of the side cell (0, dy).
    function automatic dir_t dir_side_y(input dir_t d);
        dir_t v;
        case (d)
            3'd0, 3'd5: v = 3'd3;
            3'd2, 3'd7: v = 3'd4;
            default:    v = d;
        endcase
        return v;
    endfunction

    // Program: divide over DIV_STEPS steps with the eight map reads
    // overlapped, one evaluate step, then one emit step per result.
    function automatic ucode_t ucode_rom(input step_t pc);
        ucode_t w;
        step_t  prev;
        w    = '0;
        prev = pc - step_t'(1);
        if (pc < STEP_EVAL)
        begin
            w.div_en = 1'b1;
        end
        if (pc < step_t'(NUM_DIRS))
        begin
            w.rd_en  = 1'b1;
            w.rd_dir = pc[DIR_W-1:0];
        end
        if (pc != '0 && pc <= step_t'(NUM_DIRS))
        begin
            w.cap_en  = 1'b1;
            w.cap_dir = prev[DIR_W-1:0];
        end
        if (pc == STEP_EVAL)
        begin
            w.eval_en = 1'b1;
        end
        if (pc == STEP_EMIT)
        begin
            w.emit_en  = 1'b1;
            w.jmp_more = 1'b1;
            w.target   = STEP_EMIT;
            w.fin      = 1'b1;
        end
        if (pc > STEP_EMIT)
        begin
            w.fin = 1'b1;
        end
        return w;
    endfunction

endpackage

### rtl/gne_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gne_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/gne_seq.sv
// Microcode sequencer: step counter, conditional jump and map clearing sweep.
// Depends on gne_pkg for the program table and state type.
module gne_seq
    import gne_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query,
    input  logic             more,
    output logic             busy,
    output ucode_t           ctl,
    output logic             clr_active,
    output logic [IDX_W-1:0] clr_addr
);

    seq_state_t       state_reg, state_next;
    step_t            pc_reg, pc_next;
    logic [IDX_W-1:0] clr_reg, clr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            pc_reg    <= '0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            clr_reg   <= clr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        clr_next   = clr_reg;
        ctl        = '0;
        busy       = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy = 1'b0;
                if (query)
                begin
                    state_next = ST_RUN;
                    pc_next    = '0;
                end
            end
            ST_RUN:
            begin
                ctl = ucode_rom(pc_reg);
                if (ctl.jmp_more && more)
                begin
                    pc_next = ctl.target;
                end
                else if (ctl.fin)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    pc_next = pc_reg + step_t'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign clr_active = (state_reg == ST_CLEAR);
    assign clr_addr   = clr_reg;

endmodule

### rtl/gne_dp.sv
// Datapath: restoring divider, neighbor address adder, reachability logic
// and result registers. Driven by the control word from gne_seq; uses gne_pkg.
module gne_dp
    import gne_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [IDX_W-1:0] load_index,
    input  logic [CFG_W-1:0] width,
    input  logic [CFG_W-1:0] height,
    input  logic             diag_en,
    input  logic             cut_en,
    input  logic             sqz_en,
    input  ucode_t           ctl,
    input  logic             ram_rdata,
    output logic [IDX_W-1:0] ram_raddr,
    output logic             more,
    output logic             strobe,
    output logic [IDX_W-1:0] neighbor_index,
    output logic             neighbor_valid,
    output logic [DEG_W-1:0] degree,
    output logic             last
);

    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    quo_reg, quo_next;
    logic [CFG_W-1:0]    rem_reg, rem_next;
    logic                rd_st_reg;
    logic [NUM_DIRS-1:0] blk_reg;
    logic [NUM_DIRS-1:0] st_reg;
    logic [NUM_DIRS-1:0] mask_reg;
    logic [DEG_W-1:0]    deg_reg;

    logic                strobe_reg;
    logic [IDX_W-1:0]    nidx_reg;
    logic                nvalid_reg;
    logic [DEG_W-1:0]    degree_reg;
    logic                last_reg;

    // Divider step: shift one dividend bit into the remainder.
    logic [CFG_W:0] trial;
    logic           ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[IDX_W-1]};
        ge       = (trial >= {1'b0, width});
        rem_next = ge ? CFG_W'(trial - {1'b0, width}) : trial[CFG_W-1:0];
        quo_next = {quo_reg[IDX_W-2:0], ge};
    end

    // Emit selection: lowest remaining direction first.
    dir_t                sel;
    logic [NUM_DIRS-1:0] rest;
    logic                any;

    always_comb
    begin
        sel = '0;
        for (int d = NUM_DIRS - 1; d >= 0; d--)
        begin
            if (mask_reg[d])
            begin
                sel = dir_t'(d);
            end
        end
        any  = (mask_reg != '0);
        rest = mask_reg & ~(NUM_DIRS'(1) << sel);
    end

    assign more = (rest != '0);

    // Shared adder: cell index plus dy * width plus dx.
    dir_t                   addr_dir;
    logic signed [1:0]      adx, ady;
    logic signed [SA_W-1:0] wext, off_y, sa_sum;
    logic                   in_store;

    always_comb
    begin
        addr_dir = ctl.emit_en ? sel : ctl.rd_dir;
        adx      = dir_dx(addr_dir);
        ady      = dir_dy(addr_dir);
        wext     = $signed({{(SA_W - CFG_W){1'b0}}, width});
        if (ady == 2'sd1)
        begin
            off_y = wext;
        end
        else if (ady == -2'sd1)
        begin
            off_y = -wext;
        end
        else
        begin
            off_y = '0;
        end
        sa_sum   = $signed({{(SA_W - IDX_W){1'b0}}, idx_reg}) + off_y
                 + $signed({{(SA_W - 2){adx[1]}}, adx});
        in_store = !sa_sum[SA_W-1] && (sa_sum[SA_W-2:0] < (SA_W - 1)'(MAP_DEPTH));
    end

    assign ram_raddr = sa_sum[IDX_W-1:0];

    // Reachability of all eight directions from the captured map bits.
    logic                   xlo_ok, xhi_ok, ylo_ok, yhi_ok, qvalid;
    logic signed [1:0]      dxv, dyv;
    logic [1:0]             near;
    logic                   ex, diag;
    logic [NUM_DIRS-1:0]    ok;
    logic [DEG_W-1:0]       cnt;

    always_comb
    begin
        qvalid = (quo_reg < IDX_W'(height));
        xlo_ok = (rem_reg != '0);
        xhi_ok = (({1'b0, rem_reg} + (CFG_W + 1)'(1)) < {1'b0, width});
        ylo_ok = (quo_reg != '0);
        yhi_ok = (({1'b0, quo_reg} + (IDX_W + 1)'(1)) < (IDX_W + 1)'(height));
        ok     = '0;
        dxv    = '0;
        dyv    = '0;
        near   = '0;
        ex     = 1'b0;
        diag   = 1'b0;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            dxv  = dir_dx(dir_t'(d));
            dyv  = dir_dy(dir_t'(d));
            ex   = qvalid && st_reg[d]
                && ((dxv == -2'sd1) ? xlo_ok : (dxv == 2'sd1) ? xhi_ok : 1'b1)
                && ((dyv == -2'sd1) ? ylo_ok : (dyv == 2'sd1) ? yhi_ok : 1'b1);
            near = {1'b0, blk_reg[dir_side_x(dir_t'(d))]}
                 + {1'b0, blk_reg[dir_side_y(dir_t'(d))]};
            diag = (dxv != 2'sd0) && (dyv != 2'sd0);
            ok[d] = ex && !blk_reg[d]
                 && (!diag || (diag_en && (near == 2'd0 || cut_en)
                               && (near != 2'd2 || sqz_en)));
        end
        cnt = '0;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            cnt = cnt + DEG_W'(ok[d]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            idx_reg <= load_index;
            quo_reg <= load_index;
            rem_reg <= '0;
        end
        else if (ctl.div_en)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (ctl.rd_en)
        begin
            rd_st_reg <= in_store;
        end
        // Cells past the store read as free and are never neighbors.
        if (ctl.cap_en)
        begin
            blk_reg[ctl.cap_dir] <= ram_rdata && rd_st_reg;
            st_reg[ctl.cap_dir]  <= rd_st_reg;
        end
        if (ctl.eval_en)
        begin
            mask_reg <= ok;
            deg_reg  <= cnt;
        end
        else if (ctl.emit_en)
        begin
            mask_reg <= rest;
        end
        if (ctl.emit_en)
        begin
            nidx_reg   <= any ? sa_sum[IDX_W-1:0] : '0;
            nvalid_reg <= any;
            degree_reg <= deg_reg;
            last_reg   <= !more;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctl.emit_en;
        end
    end

    assign strobe         = strobe_reg;
    assign neighbor_index = nidx_reg;
    assign neighbor_valid = nvalid_reg;
    assign degree         = degree_reg;
    assign last           = last_reg;

endmodule

### rtl/grid_neighbor_expander_core.sv
// Top level of the grid neighbor expander: configuration registers, obstacle
// map RAM, microcode sequencer and datapath. Uses gne_pkg, gne_ram, gne_seq, gne_dp.
//
// A request is taken when start is high and busy is low. A write request
// (mode 0) stores the obstacle bit at cell_index in that same cycle and gives
// no result; busy stays low, so writes go at one per cycle. A query request
// (mode 1) runs a program: twelve restoring-divider steps split the
// index into column and row while the eight neighbor bits are read through the
// single read port of the obstacle RAM, one evaluate step, then one emit step
// per result.
// Results follow back to back on strobe, one per cycle, and busy stays high
// through the last emit step. Results cannot be held off. After reset the
// block sweeps the 4096-entry map to zero, one cell per cycle, and holds
// busy high for the whole sweep; configuration writes are taken throughout.
module grid_neighbor_expander_core
    import gne_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 mode,
    input  logic [IDX_W-1:0]     cell_index,
    input  logic                 blocked,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 strobe,
    output logic [IDX_W-1:0]     neighbor_index,
    output logic                 neighbor_valid,
    output logic [DEG_W-1:0]     degree,
    output logic                 last
);

    logic [CFG_W-1:0] grid_width_reg;
    logic [CFG_W-1:0] grid_height_reg;
    logic             diag_en_reg;
    logic             cut_en_reg;
    logic             sqz_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            diag_en_reg     <= 1'b0;
            cut_en_reg      <= 1'b0;
            sqz_en_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                REG_DIAG_EN:     diag_en_reg     <= cfg_data[0];
                REG_CUT_EN:      cut_en_reg      <= cfg_data[0];
                REG_SQZ_EN:      sqz_en_reg      <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // Zero counts as one; oversize limits to the map dimension.
    logic [CFG_W-1:0] width_eff, height_eff;

    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            width_eff = CFG_W'(1);
        end
        else if (32'(grid_width_reg) > MAX_COLUMNS)
        begin
            width_eff = CFG_W'(MAX_COLUMNS);
        end
        else
        begin
            width_eff = grid_width_reg;
        end
        if (grid_height_reg == '0)
        begin
            height_eff = CFG_W'(1);
        end
        else if (32'(grid_height_reg) > MAX_ROWS)
        begin
            height_eff = CFG_W'(MAX_ROWS);
        end
        else
        begin
            height_eff = grid_height_reg;
        end
    end

    logic             accept;
    logic             query;
    logic             more;
    ucode_t           ctl;
    logic             clr_active;
    logic [IDX_W-1:0] clr_addr;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic             ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic             ram_rdata;

    assign accept    = start && !busy;
    assign query     = accept && mode;
    assign ram_we    = clr_active || (accept && !mode);
    assign ram_waddr = clr_active ? clr_addr : cell_index;
    assign ram_wdata = clr_active ? 1'b0 : blocked;

    gne_ram #(
        .WIDTH (1),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gne_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .query      (query),
        .more       (more),
        .busy       (busy),
        .ctl        (ctl),
        .clr_active (clr_active),
        .clr_addr   (clr_addr)
    );

    gne_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (query),
        .load_index     (cell_index),
        .width          (width_eff),
        .height         (height_eff),
        .diag_en        (diag_en_reg),
        .cut_en         (cut_en_reg),
        .sqz_en         (sqz_en_reg),
        .ctl            (ctl),
        .ram_rdata      (ram_rdata),
        .ram_raddr      (ram_raddr),
        .more           (more),
        .strobe         (strobe),
        .neighbor_index (neighbor_index),
        .neighbor_valid (neighbor_valid),
        .degree         (degree),
        .last           (last)
    );

endmodule

### rtl/gne_checker.sv
// Port-level checks on the grid neighbor expander, bound to the top level.
// Uses gne_pkg and the macros in grid_neighbor_expander_core_assert.svh.
`include "grid_neighbor_expander_core_assert.svh"

module gne_checker
    import gne_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             mode,
    input logic             strobe,
    input logic             neighbor_valid,
    input logic [DEG_W-1:0] degree,
    input logic             last
);

    // Results of one query come in an unbroken burst with one degree.
    `GNE_ASSERT_NEXT(a_burst, clk, rst_n, strobe && !last, strobe && $stable(degree), "result burst broken or degree changed")

    `GNE_ASSERT_NOW(a_empty, clk, rst_n, strobe && !neighbor_valid, last && degree == '0, "empty result not alone")

    `GNE_ASSERT_NOW(a_degree, clk, rst_n, strobe && neighbor_valid, degree != '0 && degree <= DEG_MAX, "degree out of range")

    `GNE_ASSERT_NEXT(a_query_busy, clk, rst_n, start && !busy && mode, busy, "query request did not raise busy")

endmodule

bind grid_neighbor_expander_core gne_checker u_gne_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .mode           (mode),
    .strobe         (strobe),
    .neighbor_valid (neighbor_valid),
    .degree         (degree),
    .last           (last)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for grid_neighbor_expander_core: directed and random
// obstacle writes and successor queries, checked against a local model. Needs gne_pkg.
module tb;
    import gne_pkg::*;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam int   STALL_LIMIT = 5 * MAP_DEPTH;
    localparam int   CHUNK_ITEMS = 14;

    typedef struct packed {
        logic [IDX_W-1:0] nbr;
        logic             valid;
        logic [DEG_W-1:0] deg;
        logic             is_last;
    } successor_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 mode = 1'b0;
    logic [IDX_W-1:0]     cell_index = '0;
    logic                 blocked = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 busy;
    logic                 strobe;
    logic [IDX_W-1:0]     neighbor_index;
    logic                 neighbor_valid;
    logic [DEG_W-1:0]     degree;
    logic                 last;

    // Local copy of the obstacle map and the registers
    bit               grid_map [MAP_DEPTH];
    logic [CFG_W-1:0] width_reg = CFG_W'(64);
    logic [CFG_W-1:0] height_reg = CFG_W'(64);
    logic             diag_reg = 1'b0;
    logic             cut_reg = 1'b0;
    logic             squeeze_reg = 1'b0;

    successor_t successor_q [$];
    int         error_count = 0;
    int         sender_idle_pct = 0;

    grid_neighbor_expander_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .cell_index     (cell_index),
        .blocked        (blocked),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .strobe         (strobe),
        .neighbor_index (neighbor_index),
        .neighbor_valid (neighbor_valid),
        .degree         (degree),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int clamp_dim(input int value, input int maxv);
        if (value < 1)
            return 1;
        if (value > maxv)
            return maxv;
        return value;
    endfunction

    // Append one expected result
    function automatic void expect_result(input successor_t item);
        successor_q = {successor_q, item};
    endfunction

    // Queue the successors of one query, in dx-outer, dy-inner order
    function automatic void compute_successors(input logic [IDX_W-1:0] idx);
        int               w;
        int               h;
        int               x;
        int               y;
        int               nx;
        int               ny;
        int               n;
        int               side_blocked;
        logic [IDX_W-1:0] found [NUM_DIRS];
        w = clamp_dim(int'(width_reg), MAX_COLUMNS);
        h = clamp_dim(int'(height_reg), MAX_ROWS);
        n = 0;
        if (int'(idx) < w * h)
        begin
            x = int'(idx) % w;
            y = int'(idx) / w;
            for (int dx = -1; dx <= 1; dx++)
            begin
                for (int dy = -1; dy <= 1; dy++)
                begin
                    nx = x + dx;
                    ny = y + dy;
                    if (dx == 0 && dy == 0)
                        continue;
                    if (nx < 0 || ny < 0 || nx >= w || ny >= h || ny * w + nx >= MAP_DEPTH)
                        continue;
                    if (grid_map[ny * w + nx])
                        continue;
                    if (dx != 0 && dy != 0)
                    begin
                        if (!diag_reg)
                            continue;
                        side_blocked = int'(grid_map[y * w + nx]) + int'(grid_map[ny * w + x]);
                        if ((side_blocked >= 1 && !cut_reg) || (side_blocked >= 2 && !squeeze_reg))
                            continue;
                    end
                    found[n] = IDX_W'(ny * w + nx);
                    n++;
                end
            end
        end
        if (n == 0)
            expect_result(successor_t'{nbr: '0, valid: 1'b0, deg: '0, is_last: 1'b1});
        else
            for (int k = 0; k < n; k++)
                expect_result(successor_t'{found[k], 1'b1, DEG_W'(n), k == n - 1});
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        successor_t want;
        if (rst_n && strobe)
        begin
            if (successor_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got neighbor_index %0d",
                         $time, neighbor_index);
                error_count++;
            end
            else
            begin
                want = successor_q.pop_front();
                check_field("neighbor_index", 16'(want.nbr), 16'(neighbor_index));
                check_field("neighbor_valid", 16'(want.valid), 16'(neighbor_valid));
                check_field("degree", 16'(want.deg), 16'(degree));
                check_field("last", 16'(want.is_last), 16'(last));
            end
        end
    end

    // End the run when nothing moves for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || strobe || cfg_write)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Hold until no result is pending and the block is free
    task automatic wait_idle();
        start <= 1'b0;
        while (successor_q.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_request(input logic op, input logic [IDX_W-1:0] idx,
                                input logic blk);
        start      <= 1'b1;
        mode       <= op;
        cell_index <= idx;
        blocked    <= blk;
        do
            @(posedge clk);
        while (busy);
        if (op == MODE_QUERY)
            compute_successors(idx);
        else
            grid_map[idx] = blk;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        case (sel)
            REG_GRID_WIDTH:  width_reg = value;
            REG_GRID_HEIGHT: height_reg = value;
            REG_DIAG_EN:     diag_reg = value[0];
            REG_CUT_EN:      cut_reg = value[0];
            REG_SQZ_EN:      squeeze_reg = value[0];
            default:         ;
        endcase
    endtask

    task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input logic [CFG_W-1:0] diag, input logic [CFG_W-1:0] cut,
                            input logic [CFG_W-1:0] sqz);
        wait_idle();
        put_reg(REG_GRID_WIDTH, w);
        put_reg(REG_GRID_HEIGHT, h);
        put_reg(REG_DIAG_EN, diag);
        put_reg(REG_CUT_EN, cut);
        put_reg(REG_SQZ_EN, sqz);
        // Unmapped index: must leave every register alone
        if ($urandom_range(1) == 1)
            put_reg(CFG_IDX_W'($urandom_range(int'(REG_SQZ_EN) + 1, (1 << CFG_IDX_W) - 1)),
                    CFG_W'($urandom));
        cfg_write <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(9))
            7:       return CFG_W'($urandom_range(9, 64));
            8:       return ($urandom_range(1) == 1) ? CFG_W'(0) : CFG_W'(64);
            9:       return CFG_W'($urandom);
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic test_reset_defaults();
        sender_idle_pct = 0;
        send_request(MODE_QUERY, IDX_W'(0), 1'b0);
        send_request(MODE_QUERY, IDX_W'(MAP_DEPTH - 1), 1'b0);
        send_request(MODE_QUERY, IDX_W'(2080), 1'b0);
    endtask

    // Cell 6 of a 5x4 grid with its right and lower side cells blocked
    task automatic test_corner_rules();
        set_grid(5, 4, 1, 0, 0);
        send_request(MODE_WRITE, IDX_W'(7), 1'b1);
        send_request(MODE_WRITE, IDX_W'(11), 1'b1);
        send_request(MODE_QUERY, IDX_W'(6), 1'b0);
        set_grid(5, 4, 1, 1, 0);
        send_request(MODE_QUERY, IDX_W'(6), 1'b0);
        set_grid(5, 4, 1, 1, 1);
        send_request(MODE_QUERY, IDX_W'(6), 1'b0);
        set_grid(5, 4, 1, 0, 1);
        send_request(MODE_QUERY, IDX_W'(6), 1'b0);
        // Own obstacle bit must not matter
        send_request(MODE_WRITE, IDX_W'(6), 1'b1);
        send_request(MODE_QUERY, IDX_W'(6), 1'b0);
        set_grid(5, 4, 0, 1, 1);
        send_request(MODE_QUERY, IDX_W'(6), 1'b1);
    endtask

    task automatic test_size_limits();
        set_grid(0, 0, 1, 1, 1);
        send_request(MODE_QUERY, IDX_W'(0), 1'b0);
        send_request(MODE_QUERY, IDX_W'(1), 1'b0);
        send_request(MODE_QUERY, IDX_W'(MAP_DEPTH - 1), 1'b0);
        send_request(MODE_WRITE, IDX_W'(MAP_DEPTH - 1), 1'b1);
        set_grid(127, 127, 1, 1, 1);
        send_request(MODE_QUERY, IDX_W'(MAP_DEPTH - 2), 1'b0);
        send_request(MODE_QUERY, IDX_W'(2080), 1'b0);
        set_grid(1, 64, 1, 0, 0);
        send_request(MODE_QUERY, IDX_W'(0), 1'b0);
        send_request(MODE_QUERY, IDX_W'(63), 1'b0);
        set_grid(64, 1, 1, 1, 1);
        send_request(MODE_QUERY, IDX_W'(63), 1'b0);
        send_request(MODE_QUERY, IDX_W'(64), 1'b0);
        send_request(MODE_WRITE, IDX_W'(MAP_DEPTH - 1), 1'b0);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int n_items);
        int               cells;
        int               pick;
        logic [IDX_W-1:0] idx;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % CHUNK_ITEMS == 0)
            begin
                set_grid(pick_size(), pick_size(), CFG_W'($urandom), CFG_W'($urandom),
                         CFG_W'($urandom));
                sender_idle_pct = idle_pct;
            end
            cells = clamp_dim(int'(width_reg), MAX_COLUMNS) *
                    clamp_dim(int'(height_reg), MAX_ROWS);
            idx   = IDX_W'($urandom_range(cells - 1));
            pick  = $urandom_range(99);
            if (pick < 40)
                send_request(MODE_WRITE, idx, $urandom_range(99) < 45);
            else if (pick < 45)
                send_request(MODE_WRITE, IDX_W'($urandom), 1'($urandom_range(1)));
            else if (pick < 92)
                send_request(MODE_QUERY, idx, 1'($urandom_range(1)));
            else
                send_request(MODE_QUERY, IDX_W'($urandom), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_corner_rules();
        test_size_limits();
        test_random_traffic(0, 64);
        test_random_traffic(59, 64);
        test_random_traffic(0, 64);
        test_random_traffic(27, 64);
        wait_idle();
        // Drain: catch any stray result after the last expected one
        repeat (24) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
